// ===== rtl/core/least_squares_slope_window_core_defines.svh =====
// Assertion macros for the slope window core
`ifndef LEAST_SQUARES_SLOPE_WINDOW_CORE_DEFINES_SVH
`define LEAST_SQUARES_SLOPE_WINDOW_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define LSSW_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lssw: check failed");
`define LSSW_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lssw: check failed");
`else
`define LSSW_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define LSSW_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif

`endif

// ===== rtl/core/lssw_pkg.sv =====
`default_nettype none

package lssw_pkg;

    localparam int MAX_HALF    = 31;
    localparam int SAMPLE_BITS = 16;
    localparam int WIN_DEPTH   = 2 * MAX_HALF + 1;
    localparam int ADDR_W      = $clog2(WIN_DEPTH);
    localparam int MEM_DEPTH   = 2 ** ADDR_W;
    localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
    localparam int H_W         = $clog2(MAX_HALF + 1);
    localparam int K_W         = H_W + 2;
    localparam int MUL_W       = SAMPLE_BITS + K_W;
    localparam int WS_W        = SAMPLE_BITS + $clog2(MAX_HALF * (MAX_HALF + 1)) + 1;
    localparam int PS_W        = SAMPLE_BITS + $clog2(WIN_DEPTH + 1);

    localparam int CFG_HALF_W  = 5;
    localparam int SCALE_W     = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_SCALE = 1'b1;
    localparam logic [SCALE_W-1:0]   SCALE_RESET    = 32'h8000_0000;

    localparam int SLOPE_W     = 24;
    localparam int FRAC_SHIFT  = 24;
    localparam int PROD_W      = WS_W + SCALE_W;
    localparam int Q_W         = PROD_W + 1 - FRAC_SHIFT;
    localparam longint RND_HALF      = 64'd1 << (FRAC_SHIFT - 1);
    localparam longint SLOPE_NEG_MAG = 64'd1 << (SLOPE_W - 1);
    localparam longint SLOPE_POS_MAX = SLOPE_NEG_MAG - 1;
    localparam logic [SLOPE_W-1:0] SLOPE_MIN_BITS = {1'b1, {(SLOPE_W - 1){1'b0}}};
    localparam logic [SLOPE_W-1:0] SLOPE_MAX_BITS = {1'b0, {(SLOPE_W - 1){1'b1}}};

    typedef struct packed {
        logic [H_W-1:0] h;
        logic           h_dirty;
    } t_win_cfg;

    typedef struct packed {
        logic                   valid;
        logic signed [WS_W-1:0] ws;
        logic                   full;
        logic                   col_end;
    } t_sum_res;

endpackage

`default_nettype wire

// ===== rtl/core/lssw_in_if.sv =====
`default_nettype none

interface lssw_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lssw_pkg::SAMPLE_BITS-1:0] sample;
    logic                                  last_in_column;

    modport source (output valid, output sample, output last_in_column, input ready);
    modport sink (input valid, input sample, input last_in_column, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lssw_out_if.sv =====
`default_nettype none

interface lssw_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [lssw_pkg::SLOPE_W-1:0] slope;
    logic                                slope_valid;
    logic                                column_end;

    modport source (output valid, output slope, output slope_valid, output column_end,
                    input ready);
    modport sink (input valid, input slope, input slope_valid, input column_end,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lssw_sum_unit.sv =====
`default_nettype none

module lssw_sum_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lssw_pkg::t_win_cfg i_cfg,
    lssw_in_if.sink                 i_in,
    output lssw_pkg::t_sum_res      o_res,
    input  wire logic               i_res_ready
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_REC, S_HAND} t_state;

    t_state r_state;

    logic signed [lssw_pkg::SAMPLE_BITS-1:0] r_mem [lssw_pkg::MEM_DEPTH];
    logic signed [lssw_pkg::SAMPLE_BITS-1:0] r_rd;
    logic signed [lssw_pkg::SAMPLE_BITS-1:0] r_x;
    logic signed [lssw_pkg::SAMPLE_BITS-1:0] l_w;
    logic                                    r_last;
    logic                                    r_dirty;
    logic [lssw_pkg::ADDR_W-1:0]             r_wp;
    logic [lssw_pkg::ADDR_W-1:0]             r_jd;
    logic [lssw_pkg::ADDR_W-1:0]             l_rd_addr;
    logic [lssw_pkg::ADDR_W-1:0]             l_two_h;
    logic [lssw_pkg::ADDR_W-1:0]             l_j;
    logic [lssw_pkg::FILL_W-1:0]             r_fill;
    logic [lssw_pkg::FILL_W-1:0]             n_fill;
    logic [lssw_pkg::FILL_W-1:0]             l_len;
    logic signed [lssw_pkg::WS_W-1:0]        r_ws;
    logic signed [lssw_pkg::WS_W-1:0]        n_ws;
    logic signed [lssw_pkg::WS_W-1:0]        r_res_ws;
    logic signed [lssw_pkg::PS_W-1:0]        r_ps;
    logic signed [lssw_pkg::PS_W-1:0]        n_ps;
    logic                                    r_res_full;
    logic                                    r_res_end;
    logic signed [lssw_pkg::K_W-1:0]         l_k;
    logic signed [lssw_pkg::MUL_W-1:0]       l_hx_in;
    logic signed [lssw_pkg::MUL_W-1:0]       l_hx;
    logic signed [lssw_pkg::MUL_W-1:0]       l_h1w;
    logic signed [lssw_pkg::MUL_W-1:0]       l_kw;
    logic                                    l_acc;
    logic                                    l_fin;

    assign i_in.ready    = (r_state == S_IDLE);
    assign l_acc         = (r_state == S_IDLE) && i_in.valid;
    assign o_res.valid   = (r_state == S_HAND);
    assign o_res.ws      = r_res_ws;
    assign o_res.full    = r_res_full;
    assign o_res.col_end = r_res_end;

    always_comb begin
        l_two_h = lssw_pkg::ADDR_W'({i_cfg.h, 1'b0});
        l_len   = lssw_pkg::FILL_W'({i_cfg.h, 1'b1});
        l_j     = (r_state == S_REC) ? r_jd : l_two_h;
        l_w     = (lssw_pkg::FILL_W'(l_j) < r_fill) ? r_rd : '0;

        // newest stored sample sits at r_wp - 1
        if (r_state == S_REC) begin
            l_rd_addr = r_wp - lssw_pkg::ADDR_W'(2) - r_jd;
        end else if (r_dirty) begin
            l_rd_addr = r_wp - lssw_pkg::ADDR_W'(1);
        end else begin
            l_rd_addr = r_wp - lssw_pkg::ADDR_W'(1) - l_two_h;
        end

        l_hx_in = lssw_pkg::MUL_W'($signed({1'b0, i_cfg.h}))
                * lssw_pkg::MUL_W'(i_in.sample);
        l_hx    = lssw_pkg::MUL_W'($signed({1'b0, i_cfg.h})) * lssw_pkg::MUL_W'(r_x);
        l_h1w   = lssw_pkg::MUL_W'($signed({2'b00, i_cfg.h} + lssw_pkg::K_W'(1)))
                * lssw_pkg::MUL_W'(l_w);
        l_k     = $signed(lssw_pkg::K_W'(i_cfg.h) - lssw_pkg::K_W'(1)
                          - lssw_pkg::K_W'(r_jd));
        l_kw    = lssw_pkg::MUL_W'(l_k) * lssw_pkg::MUL_W'(l_w);

        if (r_state == S_REC) begin
            n_ws = r_ws + lssw_pkg::WS_W'(l_kw);
            n_ps = r_ps + lssw_pkg::PS_W'(l_w);
        end else begin
            n_ws = r_ws - lssw_pkg::WS_W'(r_ps) + lssw_pkg::WS_W'(l_hx)
                 + lssw_pkg::WS_W'(l_h1w);
            n_ps = r_ps + lssw_pkg::PS_W'(r_x) - lssw_pkg::PS_W'(l_w);
        end

        n_fill = (r_fill == lssw_pkg::FILL_W'(lssw_pkg::WIN_DEPTH))
               ? r_fill : r_fill + lssw_pkg::FILL_W'(1);
        l_fin  = (r_state == S_RUN)
               || ((r_state == S_REC) && (r_jd == l_two_h - lssw_pkg::ADDR_W'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (l_acc) begin
            r_mem[r_wp] <= i_in.sample;
        end
        r_rd <= r_mem[l_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ws    <= '0;
            r_ps    <= '0;
            r_fill  <= '0;
            r_wp    <= '0;
            r_dirty <= 1'b0;
        end else begin
            unique case (r_state) inside
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_x    <= i_in.sample;
                        r_last <= i_in.last_in_column;
                        r_jd   <= '0;
                        if (r_dirty) begin
                            r_ws    <= lssw_pkg::WS_W'(l_hx_in);
                            r_ps    <= lssw_pkg::PS_W'(i_in.sample);
                            r_state <= S_REC;
                        end else begin
                            r_state <= S_RUN;
                        end
                    end
                end
                S_RUN, S_REC: begin
                    if (l_fin) begin
                        r_res_ws   <= n_ws;
                        r_res_full <= (n_fill >= l_len);
                        r_res_end  <= r_last;
                        r_wp       <= r_wp + lssw_pkg::ADDR_W'(1);
                        r_dirty    <= 1'b0;
                        r_state    <= S_HAND;
                        // drop the window at the end of a column
                        if (r_last) begin
                            r_ws   <= '0;
                            r_ps   <= '0;
                            r_fill <= '0;
                        end else begin
                            r_ws   <= n_ws;
                            r_ps   <= n_ps;
                            r_fill <= n_fill;
                        end
                    end else begin
                        r_ws <= n_ws;
                        r_ps <= n_ps;
                        r_jd <= r_jd + lssw_pkg::ADDR_W'(1);
                    end
                end
                S_HAND: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg.h_dirty) begin
                r_dirty <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lssw_scale_unit.sv =====
`default_nettype none

module lssw_scale_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [lssw_pkg::SCALE_W-1:0] i_scale,
    input  wire lssw_pkg::t_sum_res           i_res,
    output logic                              o_res_ready,
    lssw_out_if.source                        o_out
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_RND} t_state;

    t_state r_state;

    logic                            r_neg;
    logic                            r_full;
    logic                            r_end;
    logic [lssw_pkg::WS_W-1:0]       r_mag;
    logic [lssw_pkg::PROD_W-1:0]     r_prod;
    logic [lssw_pkg::PROD_W:0]       l_rnd;
    logic [lssw_pkg::Q_W-1:0]        l_q;
    logic [lssw_pkg::SLOPE_W-1:0]    l_slope;
    logic                            l_load;
    logic                            r_ovalid;
    logic [lssw_pkg::SLOPE_W-1:0]    r_slope;
    logic                            r_slope_valid;
    logic                            r_col_end;

    assign o_res_ready       = (r_state == S_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.slope       = r_slope;
    assign o_out.slope_valid = r_slope_valid;
    assign o_out.column_end  = r_col_end;

    always_comb begin
        l_rnd  = {1'b0, r_prod} + (lssw_pkg::PROD_W + 1)'(lssw_pkg::RND_HALF);
        l_q    = l_rnd[lssw_pkg::PROD_W:lssw_pkg::FRAC_SHIFT];
        l_load = (r_state == S_RND) && (!r_ovalid || o_out.ready);
        if (!r_full) begin
            l_slope = '0;
        end else if (r_neg) begin
            l_slope = (l_q > lssw_pkg::Q_W'(lssw_pkg::SLOPE_NEG_MAG))
                    ? lssw_pkg::SLOPE_MIN_BITS
                    : lssw_pkg::SLOPE_W'(0) - l_q[lssw_pkg::SLOPE_W-1:0];
        end else begin
            l_slope = (l_q > lssw_pkg::Q_W'(lssw_pkg::SLOPE_POS_MAX))
                    ? lssw_pkg::SLOPE_MAX_BITS
                    : l_q[lssw_pkg::SLOPE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_res.valid) begin
                        r_neg   <= i_res.ws[lssw_pkg::WS_W-1];
                        r_mag   <= i_res.ws[lssw_pkg::WS_W-1] ? -i_res.ws : i_res.ws;
                        r_full  <= i_res.full;
                        r_end   <= i_res.col_end;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= lssw_pkg::PROD_W'(r_mag) * lssw_pkg::PROD_W'(i_scale);
                    r_state <= S_RND;
                end
                S_RND: begin
                    if (l_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (l_load) begin
                r_ovalid      <= 1'b1;
                r_slope       <= l_slope;
                r_slope_valid <= r_full;
                r_col_end     <= r_end;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/least_squares_slope_window_core.sv =====
// Path: an accepted sample passes the sum unit (run state, or a full window recompute pass
//   for the first item after a half_width write), the handoff, then the scale unit's
//   multiply and round states, to a registered output while the output is free.
// Flow: a new item is accepted only after the sum unit has handed its result on.
// Reset: synchronous, active low; h returns to 1, scale to 2^31, window to empty.
`default_nettype none
`include "least_squares_slope_window_core_defines.svh"

module least_squares_slope_window_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    lssw_in_if.sink                              i_in,
    lssw_out_if.source                           o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [lssw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lssw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [lssw_pkg::CFG_HALF_W-1:0] r_half_width;
    logic [lssw_pkg::SCALE_W-1:0]    r_norm_scale;
    logic [lssw_pkg::H_W-1:0]        l_h;
    lssw_pkg::t_win_cfg              l_win_cfg;
    lssw_pkg::t_sum_res              l_res;
    logic                            l_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= lssw_pkg::CFG_HALF_W'(1);
            r_norm_scale <= lssw_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lssw_pkg::CFG_HALF_WIDTH:
                    r_half_width <= i_cfg_data[lssw_pkg::CFG_HALF_W-1:0];
                lssw_pkg::CFG_NORM_SCALE:
                    r_norm_scale <= i_cfg_data[lssw_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_half_width == '0) begin
            l_h = lssw_pkg::H_W'(1);
        end else if (int'(r_half_width) > lssw_pkg::MAX_HALF) begin
            l_h = lssw_pkg::H_W'(lssw_pkg::MAX_HALF);
        end else begin
            l_h = lssw_pkg::H_W'(r_half_width);
        end
        l_win_cfg.h       = l_h;
        l_win_cfg.h_dirty = i_cfg_we && (i_cfg_idx == lssw_pkg::CFG_HALF_WIDTH);
    end

    lssw_sum_unit u_sum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (l_win_cfg),
        .i_in        (i_in),
        .o_res       (l_res),
        .i_res_ready (l_res_ready)
    );

    lssw_scale_unit u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scale     (r_norm_scale),
        .i_res       (l_res),
        .o_res_ready (l_res_ready),
        .o_out       (o_out)
    );

    `LSSW_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `LSSW_ASSERT_NXT(a_scale_busy_after_hand, i_clk, i_rst_n, l_res.valid && l_res_ready, !l_res_ready)
    `LSSW_ASSERT_IMP(a_zero_when_not_full, i_clk, i_rst_n, o_out.valid && !o_out.slope_valid, o_out.slope == '0)

endmodule

`default_nettype wire
